@@ design/eloc_pkg.sv @@
// Shared types and constants for the XML element locator.
package eloc_pkg;

  localparam int          NAME_BYTES    = 16;
  localparam logic [4:0]  MAX_TAG_BYTES = 5'd16;
  localparam int          OUT_BITS      = 16;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [1:0] REG_TAG_LOW  = 2'd0;
  localparam logic [1:0] REG_TAG_HIGH = 2'd1;
  localparam logic [1:0] REG_TAG_LEN  = 2'd2;

  typedef enum logic [2:0] {
    PH_SEEK_OPEN  = 3'd0,
    PH_NAME_OPEN  = 3'd1,
    PH_ATTRS      = 3'd2,
    PH_CONTENT    = 3'd3,
    PH_LT         = 3'd4,
    PH_NAME_CLOSE = 3'd5
  } phase_t;

  typedef struct packed {
    logic [NAME_BYTES-1:0][7:0] name;
    logic [4:0]                 len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
    logic       is_lt;
    logic       is_gt;
    logic       is_space;
    logic       is_slash;
  } mid_item_t;

  typedef struct packed {
    logic                found;
    logic [OUT_BITS-1:0] element_start;
    logic [OUT_BITS-1:0] content_start;
    logic [OUT_BITS-1:0] content_length;
    logic [OUT_BITS-1:0] element_length;
  } result_t;

endpackage

@@ design/eloc_fifo.sv @@
// Small flip-flop queue with a combinational head, used between the stages and at the output.
module eloc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS-1:0] wr_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_BITS'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/eloc_front.sv @@
// Front stage: classifies each incoming byte against the markup characters.
module eloc_front (
  input  logic                 [7:0] text_byte,
  input  logic                       final_byte,
  output eloc_pkg::mid_item_t        item
);

  import eloc_pkg::*;

  always_comb begin
    item.text_byte  = text_byte;
    item.final_byte = final_byte;
    item.is_lt      = (text_byte == CHAR_LT);
    item.is_gt      = (text_byte == CHAR_GT);
    item.is_space   = (text_byte == CHAR_SPACE);
    item.is_slash   = (text_byte == CHAR_SLASH);
  end

endmodule

@@ design/eloc_back.sv @@
// Back stage: tag matching state machine, offset tracking and result forming.
module eloc_back #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  eloc_pkg::cfg_t      cfg,
  input  eloc_pkg::mid_item_t in_item,
  input  logic                in_valid,
  output logic                in_pop,
  input  logic                out_full,
  output logic                out_push,
  output eloc_pkg::result_t   out_item
);

  import eloc_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

  phase_t                   phase, phase_next;
  logic [4:0]               match_index, match_index_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] saved_element_start, saved_element_start_next;
  logic [POSITION_BITS-1:0] saved_content_start, saved_content_start_next;
  logic [POSITION_BITS-1:0] saved_close_position, saved_close_position_next;
  logic                     result_given, result_given_next;

  logic [4:0] eff_len;
  logic       name_ok;
  logic       name_done;
  logic       active;
  logic       hit;
  logic       step;

  assign step     = in_valid && !out_full;
  assign in_pop   = step;
  assign eff_len  = (cfg.len > MAX_TAG_BYTES) ? MAX_TAG_BYTES : cfg.len;
  assign name_ok  = (match_index < eff_len) &&
                    (in_item.text_byte == cfg.name[match_index[3:0]]);
  assign name_done = (match_index >= eff_len);
  assign active   = !result_given && (byte_position != POS_LIMIT);

  always_comb begin
    phase_next                = phase;
    match_index_next          = match_index;
    saved_element_start_next  = saved_element_start;
    saved_content_start_next  = saved_content_start;
    saved_close_position_next = saved_close_position;
    result_given_next         = result_given;
    hit                       = 1'b0;

    if (active) begin
      unique case (phase)
        PH_SEEK_OPEN: begin
          if (in_item.is_lt) begin
            phase_next       = PH_NAME_OPEN;
            match_index_next = '0;
          end
        end
        PH_NAME_OPEN: begin
          if (name_ok) begin
            match_index_next = match_index + 1'b1;
          end else if (name_done && (in_item.is_gt || in_item.is_space)) begin
            saved_element_start_next = byte_position;
            if (in_item.is_gt) begin
              saved_content_start_next = byte_position + 1'b1;
              phase_next               = PH_CONTENT;
            end else begin
              phase_next = PH_ATTRS;
            end
          end else if (in_item.is_lt) begin
            match_index_next = '0;
          end else begin
            phase_next = PH_SEEK_OPEN;
          end
        end
        PH_ATTRS: begin
          if (in_item.is_gt) begin
            saved_content_start_next = byte_position + 1'b1;
            phase_next               = PH_CONTENT;
          end
        end
        PH_CONTENT: begin
          if (in_item.is_lt) begin
            saved_close_position_next = byte_position;
            phase_next                = PH_LT;
          end
        end
        PH_LT: begin
          if (in_item.is_slash) begin
            phase_next       = PH_NAME_CLOSE;
            match_index_next = '0;
          end else if (in_item.is_lt) begin
            saved_close_position_next = byte_position;
          end else begin
            phase_next = PH_CONTENT;
          end
        end
        PH_NAME_CLOSE: begin
          if (name_ok) begin
            match_index_next = match_index + 1'b1;
          end else if (name_done && in_item.is_gt) begin
            hit = 1'b1;
          end else if (in_item.is_lt) begin
            saved_close_position_next = byte_position;
            phase_next                = PH_LT;
          end else begin
            phase_next = PH_CONTENT;
          end
        end
        default: begin
          phase_next = PH_SEEK_OPEN;
        end
      endcase
    end

    if (hit) begin
      result_given_next = 1'b1;
    end

    byte_position_next = (byte_position == POS_LIMIT) ? byte_position
                                                      : byte_position + 1'b1;

    // A final byte ends the buffer; everything but the configuration restarts.
    if (in_item.final_byte) begin
      phase_next                = PH_SEEK_OPEN;
      match_index_next          = '0;
      byte_position_next        = '0;
      saved_element_start_next  = '0;
      saved_content_start_next  = '0;
      saved_close_position_next = '0;
      result_given_next         = 1'b0;
    end
  end

  always_comb begin
    out_push = step && (hit || (in_item.final_byte && !result_given));
    if (hit) begin
      out_item.found          = 1'b1;
      out_item.element_start  = OUT_BITS'(saved_element_start);
      out_item.content_start  = OUT_BITS'(saved_content_start);
      out_item.content_length = OUT_BITS'(saved_close_position) -
                                OUT_BITS'(saved_content_start);
      out_item.element_length = OUT_BITS'(byte_position) + 1'b1 -
                                OUT_BITS'(saved_element_start);
    end else begin
      out_item = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_SEEK_OPEN;
      match_index          <= '0;
      byte_position        <= '0;
      saved_element_start  <= '0;
      saved_content_start  <= '0;
      saved_close_position <= '0;
      result_given         <= 1'b0;
    end else if (step) begin
      phase                <= phase_next;
      match_index          <= match_index_next;
      byte_position        <= byte_position_next;
      saved_element_start  <= saved_element_start_next;
      saved_content_start  <= saved_content_start_next;
      saved_close_position <= saved_close_position_next;
      result_given         <= result_given_next;
    end
  end

endmodule

@@ design/xml_element_locator_top.sv @@
// Top level of the XML element locator: config registers, stages and queues.
//
// The block scans a text buffer one byte per request and reports the first
// element whose tag name equals the configured name (up to sixteen bytes).
// Input side: a queue-like port. A byte request is taken at a rising edge
// where push is high and full is low; final_byte marks the buffer's last byte.
// Output side: while empty is low, the oldest result is on found and the four
// offset/length ports; it is taken at a rising edge where pop is high.
// Each buffer yields exactly one result: at the closing '>' of the matching
// element (found high), or at the final byte with everything zero if nothing
// matched. After the final byte the search state restarts for a new buffer.
// Throughput is one byte per cycle while the output queue is not full; the
// matching state machine in the back stage updates once per byte. The byte
// waits at the front queue's head until the back stage takes it; its result
// is then written into the output queue and shown on the output ports.
// When the receiver stops popping, the output queue fills, the back stage
// holds, the front queue fills, and full rises; no request is lost.
// Reset (rst, synchronous) empties both queues, restarts the search and sets
// the tag name to zeros with a tag length of one. Configuration is written
// through cfg_write/cfg_index/cfg_data while the block is idle.
module xml_element_locator_top #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic        found,
  output logic [15:0] element_start,
  output logic [15:0] content_start,
  output logic [15:0] content_length,
  output logic [15:0] element_length
);

  import eloc_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  // Configuration registers; the user must write them only while no byte is in flight (not enforced here).
  logic [63:0] tag_low;
  logic [63:0] tag_high;
  logic [4:0]  tag_len;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_low  <= '0;
      tag_high <= '0;
      tag_len  <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TAG_LOW:  tag_low  <= cfg_data;
        REG_TAG_HIGH: tag_high <= cfg_data;
        REG_TAG_LEN:  tag_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg.name = {tag_high, tag_low};
  assign cfg.len  = tag_len;

  // Front: classify each byte and park it in the front queue.
  mid_item_t front_item;
  mid_item_t mid_head;
  logic      mid_empty;
  logic      mid_pop;

  eloc_front u_front (
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .item       (front_item)
  );

  eloc_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_item),
    .pop       (mid_pop),
    .head      (mid_head),
    .empty     (mid_empty),
    .full      (full)
  );

  // Back: run the tag matcher one byte per cycle whenever results can drain.
  result_t back_result;
  result_t out_head;
  logic    out_push;
  logic    out_full;

  eloc_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_item  (mid_head),
    .in_valid (!mid_empty),
    .in_pop   (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_item (back_result)
  );

  // Result queue decouples the matcher from a stalling receiver.
  eloc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (back_result),
    .pop       (pop),
    .head      (out_head),
    .empty     (empty),
    .full      (out_full)
  );

  assign found          = out_head.found;
  assign element_start  = out_head.element_start;
  assign content_start  = out_head.content_start;
  assign content_length = out_head.content_length;
  assign element_length = out_head.element_length;

endmodule

@@ verif/xml_element_locator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the XML element locator: directed plan, random buffers, checks.
module testbench;
  import eloc_pkg::*;

  // Timeout, far above the slowest correct run (about fourteen hundred
  // requests, each behind the longest idle gap on both sides, plus one long
  // hold-off of the receiver).
  localparam int          CYCLE_LIMIT      = 1_000_000;
  // Cycles allowed after the last result for bytes that are still in flight
  // but cause no result.
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          LONG_HOLD        = 400;
  localparam int          REQUESTS_PER_SET = 180;
  localparam int          SETTING_COUNT    = 6;
  localparam int          PRESSURE_BYTES   = 150;
  localparam int          MAX_PRINTS       = 40;
  localparam logic [15:0] POS_MAX          = 16'hFFFF;

  typedef enum logic { ROW_TEXT, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    logic [7:0]  text;
    logic        ends_buffer;
    bit          typed;
    result_t     want;
  } plan_row_t;

  // Every input of the block has a known value from time zero.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic [7:0]  text_byte   = 8'h00;
  logic        final_byte  = 1'b0;
  logic        cfg_write   = 1'b0;
  logic [1:0]  cfg_index   = REG_TAG_LOW;
  logic [63:0] cfg_data    = '0;
  logic        pop         = 1'b0;
  logic        full;
  logic        empty;
  logic        found;
  logic [15:0] element_start;
  logic [15:0] content_start;
  logic [15:0] content_length;
  logic [15:0] element_length;

  xml_element_locator_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scanner model: a copy of the configuration and of the search state.
  // It is stepped once for every byte request the block accepts.
  logic [63:0] name_low        = '0;
  logic [63:0] name_high       = '0;
  logic [4:0]  tag_size_reg    = 5'd1;
  phase_t      scan_phase      = PH_SEEK_OPEN;
  logic [4:0]  matched         = '0;
  logic [15:0] scan_pos        = '0;
  logic [15:0] seen_elem_start = '0;
  logic [15:0] seen_body_start = '0;
  logic [15:0] seen_close_lt   = '0;
  logic        element_done    = 1'b0;

  result_t     awaited_results[$];
  plan_row_t   plan[$];
  logic [7:0]  chunk[$];
  int          mismatch_count  = 0;
  int unsigned cycle_count     = 0;

  // Idling controls. A set flag turns off the random gaps on that side, and
  // every increment of hold_requests asks the receiver for one long hold-off.
  bit          tx_steady       = 1'b0;
  bit          rx_steady       = 1'b0;
  int          hold_requests   = 0;
  int          holds_served    = 0;
  int          rx_hold_left    = 0;
  int          rx_gap_left     = 0;
  int          rx_burst_left   = 0;

  // Name length in effect: the register value, capped at sixteen bytes.
  function automatic int tag_chars();
    return (tag_size_reg > MAX_TAG_BYTES) ? NAME_BYTES : int'(tag_size_reg);
  endfunction

  function automatic logic [7:0] tag_char(input int idx);
    logic [127:0] name_bits;
    name_bits = {name_high, name_low};
    return name_bits[8 * (idx & 15) +: 8];
  endfunction

  // Advances the model by one byte. Returns 1 when the byte causes a result,
  // which is then in res.
  function automatic bit scan_byte(input logic [7:0] c, input logic ends_buffer,
                                   output result_t res);
    int len;
    bit hit;
    len = tag_chars();
    hit = 1'b0;
    res = '0;
    // Bytes after a result, and bytes at the saturated position, are not matched.
    if (!element_done && scan_pos < POS_MAX) begin
      case (scan_phase)
        PH_SEEK_OPEN: begin
          if (c == CHAR_LT) begin
            scan_phase = PH_NAME_OPEN;
            matched = '0;
          end
        end
        PH_NAME_OPEN: begin
          if (matched < len && c == tag_char(matched)) begin
            matched++;
          end else if (matched >= len && (c == CHAR_GT || c == CHAR_SPACE)) begin
            seen_elem_start = scan_pos;
            if (c == CHAR_GT) begin
              seen_body_start = scan_pos + 16'd1;
              scan_phase = PH_CONTENT;
            end else begin
              scan_phase = PH_ATTRS;
            end
          end else if (c == CHAR_LT) begin
            // A failing '<' restarts the name match right here.
            matched = '0;
          end else begin
            scan_phase = PH_SEEK_OPEN;
          end
        end
        PH_ATTRS: begin
          if (c == CHAR_GT) begin
            seen_body_start = scan_pos + 16'd1;
            scan_phase = PH_CONTENT;
          end
        end
        PH_CONTENT: begin
          if (c == CHAR_LT) begin
            seen_close_lt = scan_pos;
            scan_phase = PH_LT;
          end
        end
        PH_LT: begin
          if (c == CHAR_SLASH) begin
            scan_phase = PH_NAME_CLOSE;
            matched = '0;
          end else if (c == CHAR_LT) begin
            seen_close_lt = scan_pos;
          end else begin
            scan_phase = PH_CONTENT;
          end
        end
        PH_NAME_CLOSE: begin
          if (matched < len && c == tag_char(matched)) begin
            matched++;
          end else if (matched >= len && c == CHAR_GT) begin
            hit = 1'b1;
            res.found          = 1'b1;
            res.element_start  = seen_elem_start;
            res.content_start  = seen_body_start;
            res.content_length = seen_close_lt - seen_body_start;
            res.element_length = scan_pos + 16'd1 - seen_elem_start;
            element_done = 1'b1;
          end else if (c == CHAR_LT) begin
            seen_close_lt = scan_pos;
            scan_phase = PH_LT;
          end else begin
            scan_phase = PH_CONTENT;
          end
        end
        default: begin
          scan_phase = PH_SEEK_OPEN;
        end
      endcase
    end
    if (scan_pos < POS_MAX) begin
      scan_pos++;
    end
    // The final byte reports "not found" unless the element was already
    // reported, and in every case starts a fresh buffer.
    if (ends_buffer) begin
      if (!element_done) begin
        hit = 1'b1;
        res = '0;
      end
      scan_phase      = PH_SEEK_OPEN;
      matched         = '0;
      scan_pos        = '0;
      seen_elem_start = '0;
      seen_body_start = '0;
      seen_close_lt   = '0;
      element_done    = 1'b0;
    end
    return hit;
  endfunction

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A text byte biased toward the characters the scanner reacts to.
  function automatic logic [7:0] text_choice();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CHAR_LT;
    if (r < 25) return CHAR_GT;
    if (r < 32) return CHAR_SPACE;
    if (r < 40) return CHAR_SLASH;
    if (r < 65) return tag_char($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] seen,
                               input logic [15:0] wanted);
    if (mismatch_count < MAX_PRINTS) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
    end
    mismatch_count++;
  endtask

  // Registers change only while the block is idle, so the model's copy is
  // updated together with the write.
  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TAG_LOW:  name_low = value;
      REG_TAG_HIGH: name_high = value;
      REG_TAG_LEN:  tag_size_reg = value[4:0];
      default: ;
    endcase
  endtask

  // Stops offering requests, waits for every expected result, then lets the
  // bytes that cause no result finish inside the block.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one byte request after an idle gap and waits until it is taken.
  // A typed expectation replaces the model's result for that byte.
  task automatic offer_byte(input logic [7:0] value, input logic ends_buffer, input int gap,
                            input bit typed, input result_t want);
    result_t predicted;
    bit      produces;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push       <= 1'b1;
    text_byte  <= value;
    final_byte <= ends_buffer;
    @(posedge clk);
    while (full) @(posedge clk);
    produces = scan_byte(value, ends_buffer, predicted);
    if (typed) begin
      awaited_results.push_back(want);
    end else if (produces) begin
      awaited_results.push_back(predicted);
    end
  endtask

  task automatic send_text(input logic [7:0] value, input logic ends_buffer);
    offer_byte(value, ends_buffer, tx_steady ? 0 : idle_length(), 1'b0, '0);
  endtask

  task automatic plan_text(input logic [7:0] value, input logic ends_buffer);
    plan_row_t row;
    row = '{ROW_TEXT, REG_TAG_LOW, '0, value, ends_buffer, 1'b0, '0};
    plan.push_back(row);
  endtask

  task automatic plan_checked(input logic [7:0] value, input logic ends_buffer,
                              input result_t want);
    plan_row_t row;
    row = '{ROW_TEXT, REG_TAG_LOW, '0, value, ends_buffer, 1'b1, want};
    plan.push_back(row);
  endtask

  task automatic plan_register(input logic [1:0] idx, input logic [63:0] value);
    plan_row_t row;
    row = '{ROW_REG, idx, value, 8'h00, 1'b0, 1'b0, '0};
    plan.push_back(row);
  endtask

  task automatic put_name_prefix(input int count);
    for (int i = 0; i < count; i++) chunk.push_back(tag_char(i));
  endtask

  // Builds one buffer in chunk. Most buffers hold a well-formed element with
  // random surroundings and content, some of them with a false start before
  // the real opening or closing tag; some are broken elements, the rest noise.
  task automatic compose_buffer();
    int         len;
    int         style;
    int         k;
    logic [7:0] c;
    len = tag_chars();
    chunk.delete();
    style = $urandom_range(0, 99);
    if (style >= 85) begin
      repeat ($urandom_range(1, 10)) chunk.push_back(text_choice());
    end else begin
      repeat ($urandom_range(0, 4)) chunk.push_back(text_choice());
      if ($urandom_range(0, 3) == 0) begin
        chunk.push_back(CHAR_LT);
        put_name_prefix(len > 0 ? $urandom_range(0, len - 1) : 0);
      end
      chunk.push_back(CHAR_LT);
      put_name_prefix(len);
      if ($urandom_range(0, 1) == 1) begin
        chunk.push_back(CHAR_GT);
      end else begin
        chunk.push_back(CHAR_SPACE);
        repeat ($urandom_range(0, 3)) begin
          c = text_choice();
          chunk.push_back(c == CHAR_GT ? CHAR_SPACE : c);
        end
        chunk.push_back(CHAR_GT);
      end
      repeat ($urandom_range(0, 6)) chunk.push_back(text_choice());
      if ($urandom_range(0, 3) == 0) begin
        chunk.push_back(CHAR_LT);
        chunk.push_back(CHAR_SLASH);
        put_name_prefix(len > 0 ? $urandom_range(0, len - 1) : 0);
      end
      chunk.push_back(CHAR_LT);
      chunk.push_back(CHAR_SLASH);
      put_name_prefix(len);
      chunk.push_back(CHAR_GT);
      repeat ($urandom_range(0, 2)) chunk.push_back(text_choice());
      if (style >= 70) begin
        // Broken element: cut short, or one byte overwritten.
        k = $urandom_range(0, chunk.size() - 1);
        if ($urandom_range(0, 1) == 1) begin
          while (chunk.size() > k + 1) void'(chunk.pop_back());
        end else begin
          chunk[k] = text_choice();
        end
      end
    end
  endtask

  // Receiver: pops in random bursts with random gaps, pops every cycle while
  // rx_steady is set, and serves each long hold-off that the stimulus asks
  // for by counting it down here.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else if (rx_steady) begin
      pop <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      pop <= 1'b0;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      pop <= 1'b1;
    end else begin
      rx_burst_left = $urandom_range(0, 7);
      rx_gap_left = idle_length();
      pop <= 1'b1;
    end
  end

  // Result checker: every result taken is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && pop && !empty) begin
      got = {found, element_start, content_start, content_length, element_length};
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result, found", 16'(got.found), 16'h0);
      end else begin
        want = awaited_results.pop_front();
        if (got.found !== want.found)
          note_mismatch("found", 16'(got.found), 16'(want.found));
        if (got.element_start !== want.element_start)
          note_mismatch("element_start", got.element_start, want.element_start);
        if (got.content_start !== want.content_start)
          note_mismatch("content_start", got.content_start, want.content_start);
        if (got.content_length !== want.content_length)
          note_mismatch("content_length", got.content_length, want.content_length);
        if (got.element_length !== want.element_length)
          note_mismatch("element_length", got.element_length, want.element_length);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // A run that hangs, for example on a lost result, ends here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  len;
    int          sent;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Right after reset a lone final byte can only report that
    // no element was found, for the lowest and the highest byte value alike.
    plan_checked(8'h00, 1'b1, '0);
    plan_checked(8'hFF, 1'b1, '0);
    // Zero-length name: "<>" opens the element and "</>" closes it.
    plan_register(REG_TAG_LEN, 64'd0);
    plan_text(CHAR_LT, 1'b0);
    plan_text(CHAR_GT, 1'b0);
    plan_text(CHAR_LT, 1'b0);
    plan_text(CHAR_SLASH, 1'b0);
    plan_checked(CHAR_GT, 1'b0, {1'b1, 16'd1, 16'd2, 16'd0, 16'd4});
    // After the result the rest of the buffer is ignored; its final mark
    // gives no result.
    plan_text(8'h71, 1'b1);
    // Name "ab": a '<' that breaks the name match starts a new one, an
    // attribute space ends the name, and a doubled '<' moves the closing tag.
    plan_register(REG_TAG_LOW, 64'h6261);
    plan_register(REG_TAG_LEN, 64'd2);
    plan_text(CHAR_LT, 1'b0);
    plan_text(8'h61, 1'b0);
    plan_text(CHAR_LT, 1'b0);
    plan_text(8'h61, 1'b0);
    plan_text(8'h62, 1'b0);
    plan_text(CHAR_SPACE, 1'b0);
    plan_text(CHAR_GT, 1'b0);
    plan_text(CHAR_LT, 1'b0);
    plan_text(CHAR_LT, 1'b0);
    plan_text(CHAR_SLASH, 1'b0);
    plan_text(8'h61, 1'b0);
    plan_text(8'h62, 1'b0);
    plan_text(CHAR_GT, 1'b0);
    plan_text(8'h80, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_register(plan[i].reg_idx, plan[i].value);
      end else begin
        offer_byte(plan[i].text, plan[i].ends_buffer, idle_length(), plan[i].typed,
                   plan[i].want);
      end
    end

    // Random part: several name settings, from the all-zero and all-one
    // extremes through a zero length and lengths above sixteen. Some settings
    // run with no idling on one side.
    for (int s = 0; s < SETTING_COUNT; s++) begin
      settle();
      low  = {$urandom, $urandom};
      high = {$urandom, $urandom};
      case (s)
        0: begin
          low  = '0;
          high = '0;
          len  = 5'd1;
        end
        1: begin
          low  = '1;
          high = '1;
          len  = 5'd16;
        end
        2: len = 5'd31;
        3: len = 5'd0;
        4: len = 5'($urandom_range(2, 15));
        default: len = 5'($urandom_range(17, 30));
      endcase
      write_register(REG_TAG_LOW, low);
      write_register(REG_TAG_HIGH, high);
      write_register(REG_TAG_LEN, {59'd0, len});
      tx_steady = (s == 2);
      rx_steady = (s == 3);
      sent = 0;
      while (sent < REQUESTS_PER_SET) begin
        compose_buffer();
        foreach (chunk[i]) send_text(chunk[i], i == chunk.size() - 1);
        sent += chunk.size();
      end
    end

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering one-byte buffers, each of which yields a result,
    // so both queues fill and full has to rise.
    settle();
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    hold_requests++;
    repeat (PRESSURE_BYTES) send_text(8'($urandom_range(0, 255)), 1'b1);

    // Drain, then watch a little longer for results nobody asked for.
    settle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
